// ----- sv/ffha_pkg.sv -----
// Package for the first-fit heap allocator.
// Holds request and response types, status codes, and the control interface types.
// It depends on nothing else.
package ffha_pkg;

    localparam int ADDR_W    = 32;
    localparam int SIZE_W    = 23;
    localparam int STATUS_W  = 3;
    localparam int CFG_IDX_W = 1;
    localparam int AMOUNT_W  = SIZE_W + 1;

    localparam logic [ADDR_W-1:0] HEADER_BYTES = 32'd8;
    localparam logic [ADDR_W-1:0] PAD_BYTES    = 32'd4;

    localparam logic [ADDR_W-1:0] HEAP_START_RESET = 32'd0;
    localparam logic [ADDR_W-1:0] HEAP_END_RESET   = 32'd4063232;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_START = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEAP_END   = 1'b1;

    localparam logic [STATUS_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_ZERO     = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_OOM      = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_BAD_FREE = 3'd4;

    typedef struct packed {
        logic              operation;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] address;
    } req_t;

    typedef struct packed {
        logic [ADDR_W-1:0]   result_address;
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   bytes_used;
    } rsp_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic                start;
        logic                step;
        logic                take;
        logic                release_blk;
        logic                append;
        logic                set_status;
        logic [STATUS_W-1:0] status;
        logic                load_rsp;
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_free;
        logic at_end;
        logic fits;
        logic busy;
        logic match;
        logic oom;
        logic full;
    } dp_status_t;

endpackage

// ----- sv/ffha_dp.sv -----
// Datapath of the first-fit heap allocator: block table memory, heap registers,
// address walk and used-bytes counter. Depends on ffha_pkg; driven by ffha_ctrl.
module ffha_dp #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ffha_pkg::req_t                  req,
    input  logic                            cfg_we,
    input  logic [ffha_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]     cfg_data,
    input  ffha_pkg::ctrl_cmd_t             cmd,
    output ffha_pkg::dp_status_t            stat,
    output ffha_pkg::rsp_t                  rsp
);

    localparam int AW      = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW      = $clog2(MAX_BLOCKS + 1);
    localparam int ENTRY_W = ffha_pkg::SIZE_W + 1;

    logic [ENTRY_W-1:0] mem [MAX_BLOCKS];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [ENTRY_W-1:0] wr_data;

    logic [ffha_pkg::ADDR_W-1:0]   heap_start_reg, heap_end_reg;
    logic [ffha_pkg::ADDR_W-1:0]   top_reg, top_next;
    logic [ffha_pkg::ADDR_W-1:0]   used_reg, used_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [CW-1:0]                 idx_reg, idx_plus1;
    logic [ffha_pkg::ADDR_W-1:0]   walk_reg;
    logic                          op_reg;
    logic [ffha_pkg::SIZE_W-1:0]   size_reg;
    logic [ffha_pkg::ADDR_W-1:0]   addr_reg;
    logic [ffha_pkg::ADDR_W-1:0]   res_addr_reg;
    logic [ffha_pkg::STATUS_W-1:0] res_status_reg;
    ffha_pkg::rsp_t                rsp_reg;

    logic                          rd_busy;
    logic [ffha_pkg::SIZE_W-1:0]   rd_size;
    logic [ffha_pkg::AMOUNT_W-1:0] amount;
    logic [ffha_pkg::ADDR_W:0]     used_sum;
    logic [ffha_pkg::ADDR_W:0]     oom_sum;

    assign rd_busy   = rd_data_reg[ENTRY_W-1];
    assign rd_size   = rd_data_reg[ffha_pkg::SIZE_W-1:0];
    assign idx_plus1 = idx_reg + CW'(1);
    assign rd_addr   = cmd.start ? '0 : idx_plus1[AW-1:0];

    always_comb
    begin
        wr_en   = cmd.take || cmd.release_blk || cmd.append;
        wr_addr = idx_reg[AW-1:0];
        wr_data = {cmd.take, rd_size};
        if (cmd.append)
        begin
            wr_addr = count_reg[AW-1:0];
            wr_data = {1'b1, size_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign oom_sum = {1'b0, top_reg} + (ffha_pkg::ADDR_W + 1)'(size_reg)
                   + {1'b0, ffha_pkg::HEADER_BYTES};

    always_comb
    begin
        stat.is_free = op_reg;
        stat.at_end  = (idx_reg == count_reg);
        stat.fits    = !rd_busy && (rd_size >= size_reg);
        stat.busy    = rd_busy;
        stat.match   = (walk_reg == addr_reg);
        stat.oom     = (oom_sum >= {1'b0, heap_end_reg});
        stat.full    = (count_reg == CW'(MAX_BLOCKS));
    end

    always_comb
    begin
        amount = ffha_pkg::AMOUNT_W'(size_reg) + ffha_pkg::AMOUNT_W'(ffha_pkg::HEADER_BYTES);
        if (cmd.append)
        begin
            amount = amount + ffha_pkg::AMOUNT_W'(ffha_pkg::PAD_BYTES);
        end
        else if (cmd.release_blk)
        begin
            amount = ffha_pkg::AMOUNT_W'(rd_size)
                   + ffha_pkg::AMOUNT_W'(ffha_pkg::HEADER_BYTES);
        end
        used_sum = {1'b0, used_reg} + (ffha_pkg::ADDR_W + 1)'(amount);

        used_next  = used_reg;
        top_next   = top_reg;
        count_next = count_reg;
        if (cmd.take || cmd.append)
        begin
            used_next = used_sum[ffha_pkg::ADDR_W] ? '1 : used_sum[ffha_pkg::ADDR_W-1:0];
        end
        else if (cmd.release_blk)
        begin
            used_next = (used_reg <= ffha_pkg::ADDR_W'(amount))
                      ? '0 : used_reg - ffha_pkg::ADDR_W'(amount);
        end
        if (cmd.append)
        begin
            top_next   = top_reg + ffha_pkg::ADDR_W'(size_reg) + ffha_pkg::HEADER_BYTES
                       + ffha_pkg::PAD_BYTES;
            count_next = count_reg + CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_start_reg <= ffha_pkg::HEAP_START_RESET;
            heap_end_reg   <= ffha_pkg::HEAP_END_RESET;
            top_reg        <= ffha_pkg::HEAP_START_RESET;
            used_reg       <= '0;
            count_reg      <= '0;
        end
        else if (cfg_we && cfg_index == ffha_pkg::CFG_HEAP_START)
        begin
            heap_start_reg <= cfg_data;
            top_reg        <= cfg_data;
            used_reg       <= '0;
            count_reg      <= '0;
        end
        else
        begin
            if (cfg_we && cfg_index == ffha_pkg::CFG_HEAP_END)
            begin
                heap_end_reg <= cfg_data;
            end
            top_reg   <= top_next;
            used_reg  <= used_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            op_reg       <= req.operation;
            size_reg     <= req.request_size;
            addr_reg     <= req.address;
            idx_reg      <= '0;
            walk_reg     <= heap_start_reg + ffha_pkg::HEADER_BYTES;
            res_addr_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg  <= idx_plus1;
            walk_reg <= walk_reg + ffha_pkg::ADDR_W'(rd_size) + ffha_pkg::HEADER_BYTES
                      + ffha_pkg::PAD_BYTES;
        end
        else if (cmd.take)
        begin
            res_addr_reg <= walk_reg;
        end
        else if (cmd.append)
        begin
            res_addr_reg <= top_reg + ffha_pkg::HEADER_BYTES;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status;
        end
        if (cmd.load_rsp)
        begin
            rsp_reg.result_address <= res_addr_reg;
            rsp_reg.status         <= res_status_reg;
            rsp_reg.bytes_used     <= used_reg;
        end
    end

    assign rsp = rsp_reg;

endmodule

// ----- sv/ffha_ctrl.sv -----
// Controller of the first-fit heap allocator: sequences the table walk and the
// commit, and owns the response valid. Depends on ffha_pkg; drives ffha_dp.
module ffha_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 req_alloc_zero,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  ffha_pkg::dp_status_t stat,
    output ffha_pkg::ctrl_cmd_t  cmd
);

    ffha_pkg::ctrl_state_t state_reg, state_next;
    logic                  rsp_valid_reg, rsp_valid_next;
    logic                  rsp_free;

    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == ffha_pkg::S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = req_alloc_zero ? ffha_pkg::S_DONE : ffha_pkg::S_SCAN;
                end
            end
            ffha_pkg::S_SCAN:
            begin
                if (stat.at_end || (stat.is_free ? stat.match : stat.fits))
                begin
                    state_next = ffha_pkg::S_DONE;
                end
            end
            ffha_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    state_next = ffha_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ffha_pkg::S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        unique case (state_reg)
            ffha_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.start      = 1'b1;
                    cmd.set_status = 1'b1;
                    cmd.status     = req_alloc_zero ? ffha_pkg::STAT_ZERO : ffha_pkg::STAT_OK;
                end
            end
            ffha_pkg::S_SCAN:
            begin
                priority if (stat.at_end)
                begin
                    cmd.set_status = 1'b1;
                    priority if (stat.is_free)
                    begin
                        cmd.status = ffha_pkg::STAT_BAD_FREE;
                    end
                    else if (stat.oom)
                    begin
                        cmd.status = ffha_pkg::STAT_OOM;
                    end
                    else if (stat.full)
                    begin
                        cmd.status = ffha_pkg::STAT_FULL;
                    end
                    else
                    begin
                        cmd.status = ffha_pkg::STAT_OK;
                        cmd.append = 1'b1;
                    end
                end
                else if (stat.is_free)
                begin
                    if (stat.match)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.release_blk = stat.busy;
                        cmd.status      = stat.busy ? ffha_pkg::STAT_OK
                                                    : ffha_pkg::STAT_BAD_FREE;
                    end
                    else
                    begin
                        cmd.step = 1'b1;
                    end
                end
                else
                begin
                    cmd.take = stat.fits;
                    cmd.step = !stat.fits;
                end
            end
            ffha_pkg::S_DONE:
            begin
                if (rsp_free)
                begin
                    cmd.load_rsp   = 1'b1;
                    rsp_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ffha_pkg::S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

// ----- sv/first_fit_heap_allocator_unit.sv -----
// Top level of the first-fit heap allocator.
// Joins the controller ffha_ctrl and the datapath ffha_dp; types come from ffha_pkg.
//
// Channel    Handshake               Payload
// req        req_valid / req_ready   req (ffha_pkg::req_t)
// rsp        rsp_valid / rsp_ready   rsp (ffha_pkg::rsp_t)
// cfg        cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Response valid rises after a request is accepted and walked through S_SCAN and S_DONE, where
// the walk steps past at most MAX_BLOCKS table records, one per cycle through the registered
// read port of the block table; a zero-size allocate skips S_SCAN.
// The next request can be accepted in the same cycle that response valid rises, since the
// controller returns to S_IDLE as the response is loaded.
// Reset empties the table, sets the top to heap_start and the counter to zero;
// there is no clearing pass. A stalled response holds in the output register while the
// next request is accepted and walked; that request then waits before its response load.
module first_fit_heap_allocator_unit #(
    parameter int MAX_BLOCKS = 64
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  ffha_pkg::req_t                 req,
    output logic                           rsp_valid,
    input  logic                           rsp_ready,
    output ffha_pkg::rsp_t                 rsp,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ffha_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [ffha_pkg::ADDR_W-1:0]    cfg_data
);

    ffha_pkg::ctrl_cmd_t  cmd;
    ffha_pkg::dp_status_t stat;
    logic                 alloc_zero;

    assign cfg_ready  = 1'b1;
    assign alloc_zero = (req.operation == ffha_pkg::OP_ALLOC) && (req.request_size == '0);

    ffha_ctrl u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_ready      (req_ready),
        .req_alloc_zero (alloc_zero),
        .rsp_valid      (rsp_valid),
        .rsp_ready      (rsp_ready),
        .stat           (stat),
        .cmd            (cmd)
    );

    ffha_dp #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp       (rsp)
    );

endmodule
